@@ sv/cpse_pkg.sv @@
// Shared types and operation codes for the common prefix/suffix edit range block.
package cpse_pkg;

   localparam int OP_W   = 2;
   localparam int BYTE_W = 8;
   localparam int POS_W  = 13;

   typedef logic [OP_W-1:0]   op_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [POS_W-1:0]  pos_type;

   localparam op_type OP_APPEND_OLD = 2'd0;
   localparam op_type OP_APPEND_NEW = 2'd1;
   localparam op_type OP_FINISH     = 2'd2;

endpackage

@@ sv/cpse_if.sv @@
// Valid/ready channel interfaces for the request and response transactions.
interface cpse_req_if;
   logic              valid;
   logic              ready;
   cpse_pkg::op_type   operation;
   cpse_pkg::byte_type byte_value;

   modport source (output valid, output operation, output byte_value, input ready);
   modport sink (input valid, input operation, input byte_value, output ready);
endinterface

interface cpse_rsp_if;
   logic             valid;
   logic             ready;
   cpse_pkg::pos_type start_byte;
   cpse_pkg::pos_type old_end_byte;
   cpse_pkg::pos_type new_end_byte;
   logic             overflow;

   modport source (output valid, output start_byte, output old_end_byte,
                   output new_end_byte, output overflow, input ready);
   modport sink (input valid, input start_byte, input old_end_byte,
                 input new_end_byte, input overflow, output ready);
endinterface

@@ sv/common_prefix_suffix_edit_range.sv @@
// Top level: collects two byte buffers and reports the changed range between them.
//
// Append transactions (operation 0 or 1) and unused codes are taken one per cycle; each append
// writes its byte into the old or new store, and a byte beyond MAX_BYTES is dropped and flagged.
// A finish transaction walks both stores through their single synchronous read ports: every
// compared byte pair is read, then compared from the registered data, first over the common
// prefix and then over the common suffix; once the response register is free the result is
// loaded into it, and no request is taken until the result has been loaded into the response
// register. The response register lets appends for the next pair flow while the result waits
// to be taken.
// Result positions are the low 13 bits of the true values. The stores need no clearing after
// reset.
module common_prefix_suffix_edit_range #(
   parameter int MAX_BYTES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   cpse_req_if.sink   req_chan,
   cpse_rsp_if.source rsp_chan
);
   import cpse_pkg::*;

   localparam int LEN_W  = $clog2(MAX_BYTES + 1);
   localparam int ADDR_W = $clog2(MAX_BYTES);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_P_RD  = 3'd1;
   localparam logic [2:0] ST_P_CMP = 3'd2;
   localparam logic [2:0] ST_S_RD  = 3'd3;
   localparam logic [2:0] ST_S_CMP = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [LEN_W-1:0] old_len_ff, old_len_in;
   logic [LEN_W-1:0] new_len_ff, new_len_in;
   logic             drop_ff, drop_in;
   logic [LEN_W-1:0] head_ff, head_in;
   logic [LEN_W-1:0] old_tail_ff, old_tail_in;
   logic [LEN_W-1:0] new_tail_ff, new_tail_in;

   logic             rsp_valid_ff, rsp_valid_in;
   pos_type          rsp_start_ff, rsp_start_in;
   pos_type          rsp_old_end_ff, rsp_old_end_in;
   pos_type          rsp_new_end_ff, rsp_new_end_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   byte_type         old_mem [MAX_BYTES];
   byte_type         new_mem [MAX_BYTES];
   byte_type         old_rd_ff;
   byte_type         new_rd_ff;
   logic             old_we, new_we;
   logic [ADDR_W-1:0] old_ra, new_ra;

   logic             req_take;
   logic [LEN_W-1:0] shorter;
   logic [LEN_W-1:0] old_tail_m1;
   logic [LEN_W-1:0] new_tail_m1;
   logic             rsp_free;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign shorter        = (old_len_ff < new_len_ff) ? old_len_ff : new_len_ff;
   assign old_tail_m1    = old_tail_ff - LEN_W'(1);
   assign new_tail_m1    = new_tail_ff - LEN_W'(1);
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign old_we = req_take && (req_chan.operation == OP_APPEND_OLD) &&
                   (old_len_ff < LEN_W'(MAX_BYTES));
   assign new_we = req_take && (req_chan.operation == OP_APPEND_NEW) &&
                   (new_len_ff < LEN_W'(MAX_BYTES));
   assign old_ra = (state_ff == ST_P_RD) ? head_ff[ADDR_W-1:0] : old_tail_m1[ADDR_W-1:0];
   assign new_ra = (state_ff == ST_P_RD) ? head_ff[ADDR_W-1:0] : new_tail_m1[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (old_we) begin
         old_mem[old_len_ff[ADDR_W-1:0]] <= req_chan.byte_value;
      end
      old_rd_ff <= old_mem[old_ra];
   end

   always_ff @(posedge clock) begin
      if (new_we) begin
         new_mem[new_len_ff[ADDR_W-1:0]] <= req_chan.byte_value;
      end
      new_rd_ff <= new_mem[new_ra];
   end

   always_comb begin
      state_in       = state_ff;
      old_len_in     = old_len_ff;
      new_len_in     = new_len_ff;
      drop_in        = drop_ff;
      head_in        = head_ff;
      old_tail_in    = old_tail_ff;
      new_tail_in    = new_tail_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_start_in   = rsp_start_ff;
      rsp_old_end_in = rsp_old_end_ff;
      rsp_new_end_in = rsp_new_end_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_chan.operation)
                  OP_APPEND_OLD: begin
                     if (old_we) begin
                        old_len_in = old_len_ff + LEN_W'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  OP_APPEND_NEW: begin
                     if (new_we) begin
                        new_len_in = new_len_ff + LEN_W'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  OP_FINISH: begin
                     head_in  = '0;
                     state_in = ST_P_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_P_RD: begin
            if (head_ff < shorter) begin
               state_in = ST_P_CMP;
            end else begin
               old_tail_in = old_len_ff;
               new_tail_in = new_len_ff;
               state_in    = ST_S_RD;
            end
         end
         ST_P_CMP: begin
            if (old_rd_ff == new_rd_ff) begin
               head_in  = head_ff + LEN_W'(1);
               state_in = ST_P_RD;
            end else begin
               old_tail_in = old_len_ff;
               new_tail_in = new_len_ff;
               state_in    = ST_S_RD;
            end
         end
         ST_S_RD: begin
            if ((old_tail_ff > head_ff) && (new_tail_ff > head_ff)) begin
               state_in = ST_S_CMP;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_S_CMP: begin
            if (old_rd_ff == new_rd_ff) begin
               old_tail_in = old_tail_m1;
               new_tail_in = new_tail_m1;
               state_in    = ST_S_RD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_start_in   = POS_W'(head_ff);
               rsp_old_end_in = POS_W'(old_tail_ff);
               rsp_new_end_in = POS_W'(new_tail_ff);
               rsp_ovf_in     = drop_ff;
               old_len_in     = '0;
               new_len_in     = '0;
               drop_in        = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         old_len_ff   <= '0;
         new_len_ff   <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         old_len_ff   <= old_len_in;
         new_len_ff   <= new_len_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff        <= head_in;
      old_tail_ff    <= old_tail_in;
      new_tail_ff    <= new_tail_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_old_end_ff <= rsp_old_end_in;
      rsp_new_end_ff <= rsp_new_end_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.start_byte   = rsp_start_ff;
   assign rsp_chan.old_end_byte = rsp_old_end_ff;
   assign rsp_chan.new_end_byte = rsp_new_end_ff;
   assign rsp_chan.overflow     = rsp_ovf_ff;

endmodule
